### rtl/srpst_pkg.sv
// Shared types, codes and pattern function of the SRAM pattern self-test unit.
package srpst_pkg;

	localparam int unsigned BYTES_W = 21;
	localparam int unsigned DATA_W  = 16;
	localparam int unsigned IDX_W   = 19;
	localparam int unsigned CNT_W   = 32;

	localparam logic ACT_START = 1'b0;
	localparam logic ACT_STEP  = 1'b1;

	localparam logic [1:0] OP_NONE  = 2'd0;
	localparam logic [1:0] OP_WRITE = 2'd1;
	localparam logic [1:0] OP_READ  = 2'd2;

	localparam logic [1:0] RES_OK   = 2'd0;
	localparam logic [1:0] RES_ERR  = 2'd1;
	localparam logic [1:0] RES_BUSY = 2'd2;

	localparam logic [2:0] PASS_IDLE  = 3'd7;
	localparam logic [2:0] NUM_PASSES = 3'd5;

	localparam logic [BYTES_W-1:0] DEFAULT_BYTES = 21'd65536;
	localparam logic [DATA_W-1:0]  ADDR_PATTERN  = 16'hA5A5;

	typedef struct packed {
		logic               action;
		logic [BYTES_W-1:0] test_bytes;
		logic [DATA_W-1:0]  read_data;
	} item_t;

	typedef struct packed {
		logic [1:0]         mem_op;
		logic [IDX_W-1:0]   mem_index;
		logic [DATA_W-1:0]  mem_wdata;
		logic [1:0]         result;
		logic               start_rejected;
		logic [IDX_W-1:0]   fail_index;
		logic [DATA_W-1:0]  expected_data;
		logic [DATA_W-1:0]  actual_data;
		logic [CNT_W-1:0]   pass_count;
		logic [CNT_W-1:0]   fail_count;
		logic [BYTES_W-1:0] tested_bytes;
	} result_t;

	function automatic logic [DATA_W-1:0] pattern(input logic [2:0] pass_id,
		input logic [DATA_W-1:0] idx);
		logic [DATA_W-1:0] p;
		case (pass_id)
			3'd0: p = ADDR_PATTERN ^ idx;
			3'd1: p = 16'h0000;
			3'd2: p = 16'hFFFF;
			3'd3: p = 16'hAAAA;
			default: p = 16'h5555;
		endcase
		return p;
	endfunction

endpackage

### rtl/srpst_in_reg.sv
// Input register stage of the self-test unit.
module srpst_in_reg (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 in_valid,
	input  srpst_pkg::item_t     in_item,
	input  logic                 fire,
	output logic                 in_ready,
	output logic                 valid_s1,
	output srpst_pkg::item_t     item_s1
);
	import srpst_pkg::*;

	assign in_ready = !valid_s1 || fire;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_ready) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_ready && in_valid) begin
			item_s1 <= in_item;
		end
	end

endmodule

### rtl/srpst_seq.sv
// Test sequencer state, configuration register and per-transaction result logic.
module srpst_seq #(
	parameter int unsigned MEM_BYTES = 1048576
) (
	input  logic                             clk,
	input  logic                             arst_n,
	input  logic                             cfg_wen,
	input  logic [srpst_pkg::BYTES_W-1:0]    cfg_wdata,
	input  logic                             fire,
	input  srpst_pkg::item_t                 item,
	output srpst_pkg::result_t               res
);
	import srpst_pkg::*;

	localparam int unsigned BYTES_MAX = (1 << BYTES_W) - 1;
	localparam int unsigned CAP_INT   = (MEM_BYTES > BYTES_MAX) ? BYTES_MAX : MEM_BYTES;
	localparam logic [BYTES_W-1:0] CAP = BYTES_W'(CAP_INT);
	localparam int unsigned HW_W = $clog2(CAP_INT / 2 + 1);

	typedef struct packed {
		logic [2:0]         pass_id;
		logic               reading;
		logic [HW_W-1:0]    step;
		logic [HW_W-1:0]    total;
		logic               pending;
		logic [1:0]         status;
		logic [IDX_W-1:0]   fail_idx;
		logic [DATA_W-1:0]  fail_exp;
		logic [DATA_W-1:0]  fail_act;
		logic [CNT_W-1:0]   passes;
		logic [CNT_W-1:0]   fails;
		logic [BYTES_W-1:0] bytes;
	} seq_state_t;

	localparam seq_state_t ST_RESET = '{pass_id: PASS_IDLE, status: RES_OK, default: '0};

	seq_state_t         st_q;
	seq_state_t         st_d;
	logic [BYTES_W-1:0] dflt_q;
	logic [BYTES_W-1:0] req_bytes;
	logic [BYTES_W-1:0] clamp_bytes;
	logic [BYTES_W-1:0] even_bytes;
	logic [HW_W-1:0]    prev_idx;
	logic [CNT_W-1:0]   prev_ext;
	logic [CNT_W-1:0]   step_ext;
	logic [CNT_W-1:0]   cmd_ext;
	logic [DATA_W-1:0]  exp_data;
	logic               mismatch;
	logic               running;
	logic [1:0]         op;
	logic [HW_W-1:0]    cmd_idx;
	logic [DATA_W-1:0]  wdata;
	logic               rejected;

	always_comb begin
		st_d        = st_q;
		op          = OP_NONE;
		cmd_idx     = '0;
		wdata       = '0;
		rejected    = 1'b0;
		step_ext    = '0;
		req_bytes   = (item.test_bytes == '0) ? dflt_q : item.test_bytes;
		clamp_bytes = (req_bytes > CAP) ? CAP : req_bytes;
		even_bytes  = {clamp_bytes[BYTES_W-1:1], 1'b0};
		prev_idx    = st_q.step - HW_W'(1);
		prev_ext    = CNT_W'(prev_idx);
		exp_data    = pattern(st_q.pass_id, prev_ext[DATA_W-1:0]);
		mismatch    = st_q.pending && (item.read_data != exp_data);
		running     = st_q.pass_id < NUM_PASSES;

		if (item.action == ACT_START) begin
			if (even_bytes == '0) begin
				rejected = 1'b1;
			end else begin
				st_d.bytes    = even_bytes;
				st_d.fail_idx = '0;
				st_d.fail_exp = '0;
				st_d.fail_act = '0;
				st_d.status   = RES_BUSY;
				st_d.pass_id  = 3'd0;
				st_d.reading  = 1'b0;
				st_d.step     = '0;
				st_d.total    = HW_W'(even_bytes[BYTES_W-1:1]);
				st_d.pending  = 1'b0;
			end
		end else if (!running) begin
			st_d.pending = 1'b0;
		end else if (mismatch) begin
			st_d.fail_idx = prev_ext[IDX_W-1:0];
			st_d.fail_exp = exp_data;
			st_d.fail_act = item.read_data;
			st_d.status   = RES_ERR;
			st_d.fails    = st_q.fails + CNT_W'(1);
			st_d.pass_id  = PASS_IDLE;
			st_d.reading  = 1'b0;
			st_d.step     = '0;
			st_d.pending  = 1'b0;
		end else begin
			st_d.pending = 1'b0;
			if (st_q.reading && (st_q.step >= st_q.total)) begin
				st_d.reading = 1'b0;
				st_d.step    = '0;
				if (st_q.pass_id == NUM_PASSES - 3'd1) begin
					st_d.pass_id = PASS_IDLE;
					st_d.status  = RES_OK;
					st_d.passes  = st_q.passes + CNT_W'(1);
				end else begin
					st_d.pass_id = st_q.pass_id + 3'd1;
				end
			end
			if (st_d.pass_id < NUM_PASSES) begin
				cmd_idx  = st_d.step;
				step_ext = CNT_W'(st_d.step);
				if (!st_d.reading) begin
					op        = OP_WRITE;
					wdata     = pattern(st_d.pass_id, step_ext[DATA_W-1:0]);
					st_d.step = st_d.step + HW_W'(1);
					if (st_d.step >= st_d.total) begin
						st_d.reading = 1'b1;
						st_d.step    = '0;
					end
				end else begin
					op           = OP_READ;
					st_d.pending = 1'b1;
					st_d.step    = st_d.step + HW_W'(1);
				end
			end
		end

		cmd_ext            = CNT_W'(cmd_idx);
		res.mem_op         = op;
		res.mem_index      = cmd_ext[IDX_W-1:0];
		res.mem_wdata      = wdata;
		res.result         = st_d.status;
		res.start_rejected = rejected;
		res.fail_index     = st_d.fail_idx;
		res.expected_data  = st_d.fail_exp;
		res.actual_data    = st_d.fail_act;
		res.pass_count     = st_d.passes;
		res.fail_count     = st_d.fails;
		res.tested_bytes   = st_d.bytes;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q <= ST_RESET;
		end else if (fire) begin
			st_q <= st_d;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			dflt_q <= DEFAULT_BYTES;
		end else if (cfg_wen) begin
			dflt_q <= cfg_wdata;
		end
	end

endmodule

### rtl/srpst_out_reg.sv
// Result register of the self-test unit.
module srpst_out_reg (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 load,
	input  logic                 take,
	input  srpst_pkg::result_t   d,
	output logic                 valid_q,
	output srpst_pkg::result_t   res_q
);
	import srpst_pkg::*;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (load) begin
			valid_q <= 1'b1;
		end else if (take) begin
			valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (load) begin
			res_q <= d;
		end
	end

endmodule

### rtl/sram_pattern_self_test_unit.sv
// Top level of the SRAM pattern self-test unit.
// Drives a five-pass write/read-verify test of a 16-bit SRAM, at most one memory
// command per step transaction. The slave stream (s_tvalid/s_tready) carries
// start and step transactions: s_tuser selects start (0) or step (1); s_tdata
// carries the requested byte count and the halfword read back for the read
// issued on the previous step. Every input transaction yields exactly one
// result transaction on the master stream, holding the memory command and
// the test status, failure record, counters and tested byte count.
// cfg_wen/cfg_wdata write the default byte count used when a start asks for
// zero; write it only while no transaction is in flight.
// An accepted transaction passes the input register, then the result
// register, which drives m_tvalid; a stall on m_tready holds it in between.
// Throughput: one transaction per cycle while the result register is not
// stalled, set by the single sequencer update between the two registers.
// Reset clears both stages, idles the sequencer and restores the default
// byte count to 65536. When m_tready is low the result register holds; the
// input register still takes one more transaction, then s_tready drops.
module sram_pattern_self_test_unit #(
	parameter int unsigned MEM_BYTES = 1048576
) (
	input  logic         clk,
	input  logic         arst_n,
	input  logic         s_tvalid,
	output logic         s_tready,
	input  logic [39:0]  s_tdata,  // test_bytes[20:0], read_data[36:21], zero pad
	input  logic         s_tuser,  // action
	output logic         m_tvalid,
	input  logic         m_tready,
	// mem_op[1:0], mem_index[20:2], mem_wdata[36:21], result[38:37],
	// start_rejected[39], fail_index[58:40], expected_data[74:59],
	// actual_data[90:75], pass_count[122:91], fail_count[154:123],
	// tested_bytes[175:155]
	output logic [175:0] m_tdata,
	input  logic         cfg_wen,
	input  logic [20:0]  cfg_wdata
);
	import srpst_pkg::*;

	item_t   in_item;
	item_t   item_s1;
	result_t res_d;
	result_t res_q;
	logic    valid_s1;
	logic    fire;

	assign in_item.action     = s_tuser;
	assign in_item.test_bytes = s_tdata[20:0];
	assign in_item.read_data  = s_tdata[36:21];

	assign fire = valid_s1 && (!m_tvalid || m_tready);

	srpst_in_reg u_in (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (s_tvalid),
		.in_item  (in_item),
		.fire     (fire),
		.in_ready (s_tready),
		.valid_s1 (valid_s1),
		.item_s1  (item_s1)
	);

	srpst_seq #(
		.MEM_BYTES (MEM_BYTES)
	) u_seq (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_wen   (cfg_wen),
		.cfg_wdata (cfg_wdata),
		.fire      (fire),
		.item      (item_s1),
		.res       (res_d)
	);

	srpst_out_reg u_out (
		.clk     (clk),
		.arst_n  (arst_n),
		.load    (fire),
		.take    (m_tready),
		.d       (res_d),
		.valid_q (m_tvalid),
		.res_q   (res_q)
	);

	assign m_tdata = {res_q.tested_bytes, res_q.fail_count, res_q.pass_count,
		res_q.actual_data, res_q.expected_data, res_q.fail_index,
		res_q.start_rejected, res_q.result, res_q.mem_wdata, res_q.mem_index,
		res_q.mem_op};

endmodule

### rtl/srpst_checker.sv
// Port-level assertions of the self-test unit and their bind.
module srpst_checker (
	input logic         clk,
	input logic         arst_n,
	input logic         m_tvalid,
	input logic         m_tready,
	input logic [175:0] m_tdata
);
	import srpst_pkg::*;

	a_hold_valid: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tready |=> m_tvalid)
		else $error("result transaction dropped while stalled");

	a_hold_data: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tready |=> $stable(m_tdata))
		else $error("result payload changed while stalled");

	a_op_legal: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid |-> (m_tdata[1:0] == OP_NONE || m_tdata[1:0] == OP_WRITE ||
		m_tdata[1:0] == OP_READ))
		else $error("illegal memory command");

	a_reject_no_cmd: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && m_tdata[39] |-> m_tdata[1:0] == OP_NONE)
		else $error("rejected start issued a memory command");

	a_cmd_busy: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && m_tdata[1:0] != OP_NONE |-> m_tdata[38:37] == RES_BUSY)
		else $error("memory command issued while no test runs");

endmodule

bind sram_pattern_self_test_unit srpst_checker u_chk (.*);
